// File: rtl/core/fixed_point_q24_8_alu_macros.svh
// Assertion macros for the fixed-point ALU.
// Used by the top level only; no other dependencies.
`ifndef FIXED_POINT_Q24_8_ALU_MACROS_SVH
`define FIXED_POINT_Q24_8_ALU_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FPA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("fpa check failed");
`define FPA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("fpa reset check failed");
`else
`define FPA_ASSERT(lbl, prop)
`define FPA_ASSERT_RST(lbl, prop)
`endif
`endif

// File: rtl/core/fpa_pkg.sv
// Shared opcodes and default sizes for the fixed-point ALU.
// No dependencies.
package fpa_pkg;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int CMD_W          = 4;
  localparam int WORD_W         = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 4'd0,
    CMD_SUB = 4'd1,
    CMD_MUL = 4'd2,
    CMD_DIV = 4'd3,
    CMD_MIN = 4'd4,
    CMD_MAX = 4'd5,
    CMD_INC = 4'd6,
    CMD_DEC = 4'd7,
    CMD_I2F = 4'd8,
    CMD_F2I = 4'd9
  } cmd_t;
endpackage

// File: rtl/core/fixed_point_q24_8_alu.sv
// Top level of the pipelined signed fixed-point ALU, stream ports in and out.
// Depends on fpa_pkg, fpa_alu, fpa_div_stage and the assertion macro header.
//
// Signed fixed-point ALU on DATA_WIDTH-bit words with FRAC_BITS fraction bits
// (Q24.8 by default). One beat enters per clock and one result beat leaves per
// clock while the output is not stalled; the restoring divider produces one
// quotient bit per pipeline stage.
// All opcodes travel through the same stages so results leave in order. A
// stall on the output freezes the whole pipeline; in_tready is low only while
// a finished result waits and out_tready is low. Divide by zero returns zero
// with div_by_zero set; unused opcodes return zero. The compare flags always
// reflect operand_a against operand_b.
`include "fixed_point_q24_8_alu_macros.svh"
module fixed_point_q24_8_alu #(
  parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF,
  parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // operand_a[31:0], operand_b[63:32]
  input  logic [3:0]  in_tuser,    // cmd[3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata    // result[31:0], a_less, a_equal, a_greater,
                                   // div_by_zero, zero pad [39:36]
);
  localparam int DW = DATA_WIDTH;
  localparam int QW = DATA_WIDTH + FRAC_BITS;
  localparam int SW = DATA_WIDTH + 6;
  // side vector layout
  localparam int S_LT = DW;
  localparam int S_EQ = DW + 1;
  localparam int S_GT = DW + 2;
  localparam int S_DV = DW + 3;
  localparam int S_DZ = DW + 4;
  localparam int S_QS = DW + 5;

  logic en;

  // input register
  logic                      in_vld_r;
  logic [fpa_pkg::CMD_W-1:0] cmd_r;
  logic signed [DW-1:0]      a_r, b_r;

  // whole pipeline moves when the output slot is free or being drained
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (en) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_r <= in_tuser;
      a_r   <= in_tdata[DW-1:0];
      b_r   <= in_tdata[32 +: DW];
    end
  end

  // non-divide ops and divider setup
  logic          v_s   [0:QW];
  logic [DW-1:0] rem_s [0:QW];
  logic [QW-1:0] nq_s  [0:QW];
  logic [DW-1:0] d_s   [0:QW];
  logic [SW-1:0] side_s[0:QW];
  logic [DW-1:0] a_mag;

  fpa_alu #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_vld_r),
    .cmd_i  (cmd_r),
    .a_i    (a_r),
    .b_i    (b_r),
    .vld_o  (v_s[0]),
    .side_o (side_s[0]),
    .a_mag_o(a_mag),
    .b_mag_o(d_s[0])
  );

  // dividend is |a| shifted up by the fraction bits
  assign rem_s[0] = '0;
  assign nq_s[0]  = QW'(a_mag) << FRAC_BITS;

  for (genvar i = 0; i < QW; i++) begin : g_div
    fpa_div_stage #(.DW(DW), .QW(QW), .SW(SW)) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (v_s[i]),
      .rem_i (rem_s[i]),
      .nq_i  (nq_s[i]),
      .d_i   (d_s[i]),
      .side_i(side_s[i]),
      .vld_o (v_s[i+1]),
      .rem_o (rem_s[i+1]),
      .nq_o  (nq_s[i+1]),
      .d_o   (d_s[i+1]),
      .side_o(side_s[i+1])
    );
  end

  // final select: apply quotient sign, pick divide or simple result
  logic [SW-1:0]        side_l;
  logic [DW-1:0]        q;
  logic signed [DW-1:0] res_nxt;
  logic                 out_valid_r;
  logic [39:0]          out_data_r;

  always_comb begin
    side_l = side_s[QW];
    q      = nq_s[QW][DW-1:0];
    if (side_l[S_DV]) begin
      res_nxt = side_l[S_DZ] ? '0 : (side_l[S_QS] ? -q : q);
    end else begin
      res_nxt = side_l[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_s[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {4'b0000, side_l[S_DZ], side_l[S_GT], side_l[S_EQ], side_l[S_LT],
                     32'($signed(res_nxt))};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // exactly one compare flag per result
  `FPA_ASSERT(a_flags_onehot, out_tvalid |-> $onehot(out_tdata[34:32]))
  // zero divisor always gives a zero result
  `FPA_ASSERT(a_dz_zero, out_tvalid && out_tdata[35] |-> out_tdata[31:0] == 32'd0)
  // pad bits stay clear
  `FPA_ASSERT(a_pad_zero, out_tvalid |-> out_tdata[39:36] == 4'd0)
  // no result right after reset
  `FPA_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_tvalid)
endmodule

// File: rtl/core/fpa_alu.sv
// First compute stage: the non-divide operations, compare flags and divider setup.
// Depends on fpa_pkg.
module fpa_alu #(
  parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF,
  parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic [fpa_pkg::CMD_W-1:0]     cmd_i,
  input  logic signed [DATA_WIDTH-1:0]  a_i,
  input  logic signed [DATA_WIDTH-1:0]  b_i,
  output logic                          vld_o,
  output logic [DATA_WIDTH+5:0]         side_o,   // res, lt, eq, gt, is_div, dz, qsign
  output logic [DATA_WIDTH-1:0]         a_mag_o,
  output logic [DATA_WIDTH-1:0]         b_mag_o
);
  localparam int DW = DATA_WIDTH;

  logic signed [2*DW-1:0] prod;
  logic signed [DW-1:0]   res;
  logic                   lt, eq, gt, is_div, dz;
  logic                   vld_r;
  logic [DW+5:0]          side_r;
  logic [DW-1:0]          a_mag_r, b_mag_r;

  always_comb begin
    prod   = a_i * b_i;
    lt     = a_i < b_i;
    eq     = a_i == b_i;
    gt     = a_i > b_i;
    is_div = fpa_pkg::cmd_t'(cmd_i) == fpa_pkg::CMD_DIV;
    dz     = is_div && (b_i == '0);
    case (fpa_pkg::cmd_t'(cmd_i))
      fpa_pkg::CMD_ADD: res = a_i + b_i;
      fpa_pkg::CMD_SUB: res = a_i - b_i;
      fpa_pkg::CMD_MUL: res = prod[FRAC_BITS +: DW];
      fpa_pkg::CMD_MIN: res = lt ? a_i : b_i;
      fpa_pkg::CMD_MAX: res = gt ? a_i : b_i;
      fpa_pkg::CMD_INC: res = a_i + DW'(1);
      fpa_pkg::CMD_DEC: res = a_i - DW'(1);
      fpa_pkg::CMD_I2F: res = a_i <<< FRAC_BITS;
      fpa_pkg::CMD_F2I: res = a_i >>> FRAC_BITS;
      default:          res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r  <= {a_i[DW-1] ^ b_i[DW-1], dz, is_div, gt, eq, lt, res};
      a_mag_r <= a_i[DW-1] ? DW'(-a_i) : DW'(a_i);
      b_mag_r <= b_i[DW-1] ? DW'(-b_i) : DW'(b_i);
    end
  end

  assign vld_o   = vld_r;
  assign side_o  = side_r;
  assign a_mag_o = a_mag_r;
  assign b_mag_o = b_mag_r;
endmodule

// File: rtl/core/fpa_div_stage.sv
// One restoring-division step: one quotient bit per register stage.
// No dependencies.
module fpa_div_stage #(
  parameter int DW = 32,
  parameter int QW = 40,
  parameter int SW = 38
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] nq_i,
  input  logic [DW-1:0] d_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [DW-1:0] rem_o,
  output logic [QW-1:0] nq_o,
  output logic [DW-1:0] d_o,
  output logic [SW-1:0] side_o
);
  logic [DW:0]   t, diff;
  logic          ge;
  logic [DW-1:0] rem_nxt;
  logic          vld_r;
  logic [DW-1:0] rem_r, d_r;
  logic [QW-1:0] nq_r;
  logic [SW-1:0] side_r;

  always_comb begin
    t       = {rem_i, nq_i[QW-1]};
    diff    = t - {1'b0, d_i};
    ge      = t >= {1'b0, d_i};
    rem_nxt = ge ? diff[DW-1:0] : t[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      nq_r   <= {nq_i[QW-2:0], ge};
      d_r    <= d_i;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign nq_o   = nq_r;
  assign d_o    = d_r;
  assign side_o = side_r;
endmodule

// File: sim/tb_fixed_point_q24_8_alu.sv
// Self-checking testbench for the pipelined Q24.8 fixed-point ALU.
// Depends on fpa_pkg and the fixed_point_q24_8_alu top level.
`timescale 1ns / 1ps
module tb_fixed_point_q24_8_alu;

  localparam int FRAC = fpa_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = fpa_pkg::DATA_WIDTH_DEF + fpa_pkg::FRAC_BITS_DEF + 3;

  typedef struct packed {
    logic        div_by_zero;
    logic        a_greater;
    logic        a_equal;
    logic        a_less;
    logic [31:0] result;
  } alu_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;    // operand_a[31:0], operand_b[63:32]
  logic [3:0]  in_tuser = '0;    // cmd[3:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // result[31:0], a_less, a_equal, a_greater,
                                 // div_by_zero, pad

  alu_res_t expected_q[$];
  int       errors = 0;
  int       beats_sent = 0;
  int       beats_checked = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_off_cycles = 0;

  fixed_point_q24_8_alu u_dut (.*);

  always #4 clk = ~clk;

  // Compute the expected result beat for one operation.
  function automatic alu_res_t alu_predict(logic [3:0] op, logic signed [31:0] a,
                                           logic signed [31:0] b);
    alu_res_t r;
    logic signed [63:0] wide;
    r = '0;
    r.a_less    = a < b;
    r.a_equal   = a == b;
    r.a_greater = a > b;
    case (op)
      fpa_pkg::CMD_ADD: r.result = a + b;
      fpa_pkg::CMD_SUB: r.result = a - b;
      fpa_pkg::CMD_MUL: begin
        wide = 64'(a) * 64'(b);
        r.result = 32'(wide >>> FRAC);
      end
      fpa_pkg::CMD_DIV: begin
        if (b == 0) begin
          r.div_by_zero = 1'b1;
        end else begin
          wide = (64'(a) <<< FRAC) / 64'(b);
          r.result = 32'(wide);
        end
      end
      fpa_pkg::CMD_MIN: r.result = (a < b) ? a : b;
      fpa_pkg::CMD_MAX: r.result = (a > b) ? a : b;
      fpa_pkg::CMD_INC: r.result = a + 1;
      fpa_pkg::CMD_DEC: r.result = a - 1;
      fpa_pkg::CMD_I2F: r.result = a <<< FRAC;
      fpa_pkg::CMD_F2I: r.result = a >>> FRAC;
      default: r.result = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH beat %0d %s: got %h want %h", beats_checked, what, got, want);
    errors++;
  endtask

  // Drive one beat at the falling edge; hold it until accepted.
  task automatic send_op(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {b, a};
    expected_q.push_back(alu_predict(op, a, b));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus an explicit long hold-off when asked.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Checker: compare each accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    alu_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = alu_res_t'(out_tdata[35:0]);
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[31:0], 32'd0);
      end else begin
        want = expected_q.pop_front();
        if (got.result !== want.result) report_mismatch("result", got.result, want.result);
        if (got.a_less !== want.a_less)
          report_mismatch("a_less", 32'(got.a_less), 32'(want.a_less));
        if (got.a_equal !== want.a_equal)
          report_mismatch("a_equal", 32'(got.a_equal), 32'(want.a_equal));
        if (got.a_greater !== want.a_greater)
          report_mismatch("a_greater", 32'(got.a_greater), 32'(want.a_greater));
        if (got.div_by_zero !== want.div_by_zero)
          report_mismatch("div_by_zero", 32'(got.div_by_zero), 32'(want.div_by_zero));
      end
      beats_checked++;
    end
  end

  // Drop the input, wait for every result, and return at a falling edge.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(2047)) - 32'd1024;
      3: return 32'($urandom_range(255)) << FRAC;
      default: return $urandom();
    endcase
  endfunction

  // Extremes, every opcode, zero divisor, unused opcodes, ties, negative shifts.
  task automatic test_directed();
    logic [3:0] op;
    send_op(fpa_pkg::CMD_ADD, 32'h7fff_ffff, 32'h0000_0001);
    send_op(fpa_pkg::CMD_SUB, 32'h8000_0000, 32'h0000_0001);
    send_op(fpa_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000);
    send_op(fpa_pkg::CMD_MUL, 32'hffff_ff80, 32'h0000_0180);
    send_op(fpa_pkg::CMD_DIV, 32'h0000_0300, 32'h0000_0000);
    send_op(fpa_pkg::CMD_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_op(fpa_pkg::CMD_DIV, 32'hffff_fd00, 32'h0000_0200);
    send_op(fpa_pkg::CMD_MIN, 32'h0000_1234, 32'h0000_1234);
    send_op(fpa_pkg::CMD_MAX, 32'h8000_0000, 32'h7fff_ffff);
    send_op(fpa_pkg::CMD_INC, 32'h7fff_ffff, 32'hffff_ffff);
    send_op(fpa_pkg::CMD_DEC, 32'h8000_0000, 32'h0000_0000);
    send_op(fpa_pkg::CMD_I2F, 32'hffff_ffff, 32'h0000_0005);
    send_op(fpa_pkg::CMD_F2I, 32'hffff_ff01, 32'h0000_0000);
    send_op(fpa_pkg::CMD_F2I, 32'h7fff_ffff, 32'h8000_0000);
    for (int i = 10; i < 16; i++) begin
      op = 4'(i);
      send_op(op, $urandom(), $urandom());
    end
    wait_drained();
  endtask

  task automatic test_random(int n, int idle, int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      send_op(4'($urandom_range(15)), rand_operand(), rand_operand());
    end
    wait_drained();
  endtask

  // Stall the output long enough to fill the pipeline and push back on input.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    hold_off_cycles = 3 * LATENCY;
    for (int i = 0; i < 2 * LATENCY; i++)
      send_op(4'($urandom_range(9)), $urandom(), $urandom());
    // Pause until every result is back, then resume.
    wait_drained();
    for (int i = 0; i < 10; i++) send_op(4'($urandom_range(9)), $urandom(), $urandom());
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(70, 0, 0);
    test_random(70, 71, 0);
    test_random(70, 0, 71);
    test_random(70, 6, 6);
    test_backpressure();
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered all opcodes, unused codes, zero divisor and extremes:");
    $display("%0d beats sent, %0d results checked under stalls", beats_sent, beats_checked);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("fixed_point_q24_8_alu test passed");
    end else begin
      $display("fixed_point_q24_8_alu test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("fixed_point_q24_8_alu test failed");
    $finish;
  end
endmodule
